@@ hw/rtl/vector_to_relative_angles_unit_defines.svh @@
// Assertion macros for the relative angle unit.
`ifndef VECTOR_TO_RELATIVE_ANGLES_UNIT_DEFINES_SVH
`define VECTOR_TO_RELATIVE_ANGLES_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define V2RA_CHECK(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("v2ra check failed");

// Next-cycle implication, also checked through reset.
`define V2RA_CHECK_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("v2ra next-cycle check failed");

`endif

@@ hw/rtl/v2ra_pkg.sv @@
// Shared widths, constants, types and functions of the relative angle unit.
`default_nettype none
package v2ra_pkg;

   localparam int POS_W      = 24;
   localparam int DIFF_W     = 25;
   localparam int SQ_W       = 50;
   localparam int SQ_SHIFT   = 14;
   localparam int RAD_W      = SQ_W + SQ_SHIFT;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int FRAC_SHIFT = 7;
   localparam int CIN_W      = 34;
   localparam int CD_W       = 60;
   localparam int MAG_W      = 56;
   localparam int NORM_BIT   = 54;
   localparam int NNORM      = 6;
   localparam int ACC_W      = 27;
   localparam int ROUND_SHIFT = 9;
   localparam int RND_W      = ACC_W - ROUND_SHIFT;
   localparam int ANG_W      = 20;
   localparam int VIEW_W     = 17;
   localparam int OUT_W      = 16;
   localparam int TABLE_LEN  = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 24;
   localparam logic [CFG_IDX_W-1:0] CFG_EYE_X      = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_EYE_Y      = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_EYE_Z      = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_VIEW_PITCH = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_VIEW_YAW   = 3'd4;

   localparam logic signed [ANG_W-1:0] FULL_TURN     = 20'sd46080;
   localparam logic signed [ANG_W-1:0] HALF_TURN     = 20'sd23040;
   localparam logic signed [ANG_W-1:0] QUARTER       = 20'sd11520;
   localparam logic signed [ANG_W-1:0] THREE_QUARTER = 20'sd34560;
   localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = 27'sd11796480;
   localparam logic signed [ACC_W-1:0] ROUND_HALF    = 27'sd256;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dz;
      logic                     dx_zero;
      logic                     dy_pos;
      logic                     dxy_zero;
      logic                     dz_pos;
   } v2ra_side_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
      logic signed [ACC_W-1:0] v;
      case (idx)
         0:  v = 27'sd2949120;
         1:  v = 27'sd1740967;
         2:  v = 27'sd919879;
         3:  v = 27'sd466945;
         4:  v = 27'sd234379;
         5:  v = 27'sd117304;
         6:  v = 27'sd58666;
         7:  v = 27'sd29335;
         8:  v = 27'sd14668;
         9:  v = 27'sd7334;
         10: v = 27'sd3667;
         11: v = 27'sd1833;
         12: v = 27'sd917;
         13: v = 27'sd458;
         14: v = 27'sd229;
         15: v = 27'sd115;
         16: v = 27'sd57;
         17: v = 27'sd29;
         18: v = 27'sd14;
         19: v = 27'sd7;
         20: v = 27'sd4;
         21: v = 27'sd2;
         22: v = 27'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // one conditional full-turn step into [-180, 180]
   function automatic logic signed [ANG_W-1:0] fold(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W-1:0] r;
      if (a > HALF_TURN) begin
         r = a - FULL_TURN;
      end else if (a < -HALF_TURN) begin
         r = a + FULL_TURN;
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/v2ra_req_if.sv @@
// Target point channel: valid, ready and the target coordinates.
`default_nettype none
interface v2ra_req_if import v2ra_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] target_x;
   logic signed [POS_W-1:0] target_y;
   logic signed [POS_W-1:0] target_z;

   modport source (output valid, output target_x, output target_y, output target_z,
                   input ready);
   modport sink   (input valid, input target_x, input target_y, input target_z,
                   output ready);
endinterface
`default_nettype wire

@@ hw/rtl/v2ra_rsp_if.sv @@
// Result channel: valid, ready and the pitch and yaw offsets.
`default_nettype none
interface v2ra_rsp_if import v2ra_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] pitch_offset;
   logic signed [OUT_W-1:0] yaw_offset;

   modport source (output valid, output pitch_offset, output yaw_offset, input ready);
   modport sink   (input valid, input pitch_offset, input yaw_offset, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/v2ra_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module v2ra_isqrt import v2ra_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_vld,
   input  wire logic [RAD_W-1:0]  in_rad,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_vld,
   output logic [ROOT_W-1:0]      out_root,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int NST = ROOT_W;

   logic [NST-1:0]    vld_src, vld_ff;
   logic [RAD_W-1:0]  rad_src [NST];
   logic [RAD_W-1:0]  rad_in  [NST-1];
   logic [RAD_W-1:0]  rad_ff  [NST-1];
   logic [REM_W-1:0]  rem_src [NST];
   logic [REM_W-1:0]  rem_in  [NST-1];
   logic [REM_W-1:0]  rem_ff  [NST-1];
   logic [ROOT_W-1:0] root_src [NST];
   logic [ROOT_W-1:0] root_in  [NST];
   logic [ROOT_W-1:0] root_ff  [NST];
   logic [SIDE_W-1:0] side_src [NST];
   logic [SIDE_W-1:0] side_ff  [NST];
   logic [REM_W-1:0]  trial [NST];
   logic [REM_W-1:0]  test  [NST];
   logic [NST-1:0]    ge;

   always_comb begin
      rad_src[0]  = in_rad;
      rem_src[0]  = '0;
      root_src[0] = '0;
      side_src[0] = in_side;
      vld_src[0]  = in_vld;
      for (int k = 1; k < NST; k++) begin
         rad_src[k]  = rad_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         side_src[k] = side_ff[k-1];
         vld_src[k]  = vld_ff[k-1];
      end
      for (int k = 0; k < NST; k++) begin
         trial[k]   = {rem_src[k][REM_W-3:0], rad_src[k][RAD_W-1 -: 2]};
         test[k]    = {{(REM_W-ROOT_W-2){1'b0}}, root_src[k], 2'b01};
         ge[k]      = (trial[k] >= test[k]);
         root_in[k] = {root_src[k][ROOT_W-2:0], ge[k]};
      end
      for (int k = 0; k < NST - 1; k++) begin
         rem_in[k] = ge[k] ? (trial[k] - test[k]) : trial[k];
         rad_in[k] = {rad_src[k][RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NST; k++) begin
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_src[k];
         end
         for (int k = 0; k < NST - 1; k++) begin
            rem_ff[k] <= rem_in[k];
            rad_ff[k] <= rad_in[k];
         end
      end
   end

   assign out_vld  = vld_ff[NST-1];
   assign out_root = root_ff[NST-1];
   assign out_side = side_ff[NST-1];

endmodule
`default_nettype wire

@@ hw/rtl/v2ra_cordic.sv @@
// Pipelined vectoring CORDIC: normalize, fold to right half plane, iterate, round.
`default_nettype none
module v2ra_cordic import v2ra_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF,
   parameter int SIDE_W = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_vld,
   input  wire logic signed [CIN_W-1:0] in_x,
   input  wire logic signed [CIN_W-1:0] in_y,
   input  wire logic [SIDE_W-1:0]       in_side,
   output logic                         out_vld,
   output logic signed [RND_W-1:0]      out_ang,
   output logic [SIDE_W-1:0]            out_side
);

   localparam int LAT = NNORM + 2 + STAGES;

   // magnitude stage
   logic [CIN_W-1:0]        ax, ay;
   logic signed [CD_W-1:0]  xm_ff, ym_ff;
   logic [MAG_W-1:0]        mm_ff;

   // normalize stages
   logic signed [CD_W-1:0]  xn_src [NNORM];
   logic signed [CD_W-1:0]  yn_src [NNORM];
   logic [MAG_W-1:0]        mn_src [NNORM];
   logic signed [CD_W-1:0]  xn_in  [NNORM];
   logic signed [CD_W-1:0]  yn_in  [NNORM];
   logic [MAG_W-1:0]        mn_in  [NNORM-1];
   logic signed [CD_W-1:0]  xn_ff  [NNORM];
   logic signed [CD_W-1:0]  yn_ff  [NNORM];
   logic [MAG_W-1:0]        mn_ff  [NNORM-1];
   logic [NNORM-1:0]        shl;

   // half-plane fold
   logic signed [CD_W-1:0]  xp_in, yp_in, xp_ff, yp_ff;
   logic signed [ACC_W-1:0] ap_in, ap_ff;

   // iterations; the last one registers the rounded angle only
   logic signed [CD_W-1:0]  xc_src [STAGES];
   logic signed [CD_W-1:0]  yc_src [STAGES];
   logic signed [ACC_W-1:0] ac_src [STAGES];
   logic signed [CD_W-1:0]  xc_in  [STAGES-1];
   logic signed [CD_W-1:0]  yc_in  [STAGES-1];
   logic signed [ACC_W-1:0] ac_in  [STAGES];
   logic signed [CD_W-1:0]  xc_ff  [STAGES-1];
   logic signed [CD_W-1:0]  yc_ff  [STAGES-1];
   logic signed [ACC_W-1:0] ac_ff  [STAGES-1];
   logic signed [ACC_W-1:0] rnd;
   logic signed [RND_W-1:0] ang_ff;

   logic [LAT-1:0]          vld_ff;
   logic [SIDE_W-1:0]       side_ff [LAT];

   always_comb begin
      ax = in_x[CIN_W-1] ? CIN_W'(-in_x) : CIN_W'(in_x);
      ay = in_y[CIN_W-1] ? CIN_W'(-in_y) : CIN_W'(in_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xm_ff <= {{(CD_W-CIN_W){in_x[CIN_W-1]}}, in_x};
         ym_ff <= {{(CD_W-CIN_W){in_y[CIN_W-1]}}, in_y};
         mm_ff <= {{(MAG_W-CIN_W){1'b0}}, ((ax > ay) ? ax : ay)};
      end
   end

   // shift by 32, 16, ... 1 while the magnitude stays below 2^55,
   // which leaves it in [2^54, 2^55)
   always_comb begin
      int s;
      xn_src[0] = xm_ff;
      yn_src[0] = ym_ff;
      mn_src[0] = mm_ff;
      for (int k = 1; k < NNORM; k++) begin
         xn_src[k] = xn_ff[k-1];
         yn_src[k] = yn_ff[k-1];
         mn_src[k] = mn_ff[k-1];
      end
      for (int k = 0; k < NNORM; k++) begin
         s = 1 << (NNORM - 1 - k);
         shl[k]   = ((mn_src[k] >> (NORM_BIT + 1 - s)) == '0);
         xn_in[k] = shl[k] ? (xn_src[k] <<< s) : xn_src[k];
         yn_in[k] = shl[k] ? (yn_src[k] <<< s) : yn_src[k];
      end
      for (int k = 0; k < NNORM - 1; k++) begin
         s = 1 << (NNORM - 1 - k);
         mn_in[k] = shl[k] ? (mn_src[k] << s) : mn_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NNORM; k++) begin
            xn_ff[k] <= xn_in[k];
            yn_ff[k] <= yn_in[k];
         end
         for (int k = 0; k < NNORM - 1; k++) begin
            mn_ff[k] <= mn_in[k];
         end
      end
   end

   always_comb begin
      if (xn_ff[NNORM-1] < 0) begin
         xp_in = -xn_ff[NNORM-1];
         yp_in = -yn_ff[NNORM-1];
         ap_in = (yn_ff[NNORM-1] >= 0) ? ACC_HALF_TURN : -ACC_HALF_TURN;
      end else begin
         xp_in = xn_ff[NNORM-1];
         yp_in = yn_ff[NNORM-1];
         ap_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xp_ff <= xp_in;
         yp_ff <= yp_in;
         ap_ff <= ap_in;
      end
   end

   always_comb begin
      xc_src[0] = xp_ff;
      yc_src[0] = yp_ff;
      ac_src[0] = ap_ff;
      for (int i = 1; i < STAGES; i++) begin
         xc_src[i] = xc_ff[i-1];
         yc_src[i] = yc_ff[i-1];
         ac_src[i] = ac_ff[i-1];
      end
      for (int i = 0; i < STAGES; i++) begin
         if (yc_src[i] >= 0) begin
            ac_in[i] = ac_src[i] + atan_entry(i);
         end else begin
            ac_in[i] = ac_src[i] - atan_entry(i);
         end
      end
      for (int i = 0; i < STAGES - 1; i++) begin
         if (yc_src[i] >= 0) begin
            xc_in[i] = xc_src[i] + (yc_src[i] >>> i);
            yc_in[i] = yc_src[i] - (xc_src[i] >>> i);
         end else begin
            xc_in[i] = xc_src[i] - (yc_src[i] >>> i);
            yc_in[i] = yc_src[i] + (xc_src[i] >>> i);
         end
      end
      // round to 1/128 degree, halves away from zero
      if (ac_in[STAGES-1] >= 0) begin
         rnd = (ac_in[STAGES-1] + ROUND_HALF) >>> ROUND_SHIFT;
      end else begin
         rnd = -((-ac_in[STAGES-1] + ROUND_HALF) >>> ROUND_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < STAGES - 1; i++) begin
            xc_ff[i] <= xc_in[i];
            yc_ff[i] <= yc_in[i];
            ac_ff[i] <= ac_in[i];
         end
         ang_ff <= rnd[RND_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_vld  = vld_ff[LAT-1];
   assign out_ang  = ang_ff;
   assign out_side = side_ff[LAT-1];

endmodule
`default_nettype wire

@@ hw/rtl/vector_to_relative_angles_unit.sv @@
// Top level: pitch and yaw offsets from the eye position toward a target point.
// Pipeline order: setup stages A, B and C, the square root, the CORDIC lanes, then fold stages F1 and F2.
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous): clears all valid bits and the five config registers to zero.
`default_nettype none
`include "vector_to_relative_angles_unit_defines.svh"
module vector_to_relative_angles_unit import v2ra_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   v2ra_req_if.sink                   req_chan,
   v2ra_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CFG_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_DATA_W-1:0] csr_wdata
);

   localparam int SIDE_W = $bits(v2ra_side_type);
   localparam int YSIDE_W = 3;

   // ---------------- config registers ----------------
   logic signed [POS_W-1:0]  eye_x_ff, eye_y_ff, eye_z_ff;
   logic signed [VIEW_W-1:0] view_pitch_ff, view_yaw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_x_ff      <= '0;
         eye_y_ff      <= '0;
         eye_z_ff      <= '0;
         view_pitch_ff <= '0;
         view_yaw_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_EYE_X:      eye_x_ff      <= csr_wdata;
            CFG_EYE_Y:      eye_y_ff      <= csr_wdata;
            CFG_EYE_Z:      eye_z_ff      <= csr_wdata;
            CFG_VIEW_PITCH: view_pitch_ff <= csr_wdata[VIEW_W-1:0];
            CFG_VIEW_YAW:   view_yaw_ff   <= csr_wdata[VIEW_W-1:0];
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   // ---------------- global advance ----------------
   // Every stage moves together; only a waiting result freezes the pipe.
   logic en;
   logic out_vld_ff;
   assign en = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // ---------------- stage A: direction ----------------
   logic                     a_vld_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= DIFF_W'(req_chan.target_x) - DIFF_W'(eye_x_ff);
         dy_ff <= DIFF_W'(req_chan.target_y) - DIFF_W'(eye_y_ff);
         dz_ff <= DIFF_W'(req_chan.target_z) - DIFF_W'(eye_z_ff);
      end
   end

   // ---------------- stage B: squares and flags ----------------
   logic                     b_vld_ff;
   logic signed [SQ_W-1:0]   sqx_in, sqy_in;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   v2ra_side_type            b_side_in, b_side_ff;

   always_comb begin
      sqx_in = dx_ff * dx_ff;
      sqy_in = dy_ff * dy_ff;
      b_side_in.dx       = dx_ff;
      b_side_in.dy       = dy_ff;
      b_side_in.dz       = dz_ff;
      b_side_in.dx_zero  = (dx_ff == '0);
      b_side_in.dy_pos   = !dy_ff[DIFF_W-1] && (dy_ff != '0);
      b_side_in.dxy_zero = (dx_ff == '0) && (dy_ff == '0);
      b_side_in.dz_pos   = !dz_ff[DIFF_W-1] && (dz_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
         b_side_ff <= b_side_in;
      end
   end

   // ---------------- stage C: squared horizontal length ----------------
   logic            c_vld_ff;
   logic [SQ_W-1:0] hsq_ff;
   v2ra_side_type   c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hsq_ff    <= sqx_ff + sqy_ff;
         c_side_ff <= b_side_ff;
      end
   end

   // ---------------- square root: horizontal length in 1/128 unit ----------------
   logic              s_vld;
   logic [ROOT_W-1:0] s_root;
   logic [SIDE_W-1:0] s_side_bits;
   v2ra_side_type     s_side;

   v2ra_isqrt #(
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (c_vld_ff),
      .in_rad   ({hsq_ff, {SQ_SHIFT{1'b0}}}),
      .in_side  (c_side_ff),
      .out_vld  (s_vld),
      .out_root (s_root),
      .out_side (s_side_bits)
   );

   assign s_side = v2ra_side_type'(s_side_bits);

   // ---------------- two CORDIC lanes in lockstep ----------------
   logic signed [CIN_W-1:0]  yaw_x, yaw_y, pitch_x, pitch_y;
   logic                     yaw_vld, pitch_vld;
   logic signed [RND_W-1:0]  yaw_ang, pitch_ang;
   logic [YSIDE_W-1:0]       yaw_side;
   logic                     pitch_side;

   assign yaw_x   = {{(CIN_W-DIFF_W){s_side.dx[DIFF_W-1]}}, s_side.dx};
   assign yaw_y   = {{(CIN_W-DIFF_W){s_side.dy[DIFF_W-1]}}, s_side.dy};
   assign pitch_x = {{(CIN_W-ROOT_W){1'b0}}, s_root};
   // dz scaled by 128 to match the root's unit
   assign pitch_y = {{(CIN_W-DIFF_W-FRAC_SHIFT){s_side.dz[DIFF_W-1]}}, s_side.dz,
                     {FRAC_SHIFT{1'b0}}};

   v2ra_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (YSIDE_W)
   ) u_cordic_yaw (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s_vld),
      .in_x     (yaw_x),
      .in_y     (yaw_y),
      .in_side  ({s_side.dx_zero, s_side.dy_pos, s_side.dxy_zero}),
      .out_vld  (yaw_vld),
      .out_ang  (yaw_ang),
      .out_side (yaw_side)
   );

   v2ra_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (1)
   ) u_cordic_pitch (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s_vld),
      .in_x     (pitch_x),
      .in_y     (pitch_y),
      .in_side  (s_side.dz_pos),
      .out_vld  (pitch_vld),
      .out_ang  (pitch_ang),
      .out_side (pitch_side)
   );

   // ---------------- stage F1: special directions, first fold ----------------
   logic                    f_dx_zero, f_dy_pos, f_dxy_zero;
   logic signed [ANG_W-1:0] yaw_ext, pitch_ext, yaw_raw, pitch_raw;
   logic signed [ANG_W-1:0] f1_yaw_in, f1_pitch_in, f1_yaw_ff, f1_pitch_ff;
   logic                    f1_vld_ff;

   always_comb begin
      {f_dx_zero, f_dy_pos, f_dxy_zero} = yaw_side;
      yaw_ext   = {{(ANG_W-RND_W){yaw_ang[RND_W-1]}}, yaw_ang};
      pitch_ext = {{(ANG_W-RND_W){pitch_ang[RND_W-1]}}, pitch_ang};
      // no horizontal part: yaw 0, pitch straight up or down
      priority if (f_dxy_zero) begin
         yaw_raw = '0;
      end else if (f_dx_zero) begin
         yaw_raw = f_dy_pos ? QUARTER : THREE_QUARTER;
      end else begin
         yaw_raw = (yaw_ext < 0) ? (yaw_ext + FULL_TURN) : yaw_ext;
      end
      if (f_dxy_zero) begin
         pitch_raw = pitch_side ? QUARTER : THREE_QUARTER;
      end else begin
         pitch_raw = (pitch_ext < 0) ? (pitch_ext + FULL_TURN) : pitch_ext;
      end
      f1_pitch_in = fold(-pitch_raw);
      f1_yaw_in   = fold(yaw_raw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff <= pitch_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_pitch_ff <= f1_pitch_in;
         f1_yaw_ff   <= f1_yaw_in;
      end
   end

   // ---------------- stage F2: subtract view, fold, output register ----------------
   logic signed [ANG_W-1:0] pitch_rel, yaw_rel;
   logic signed [OUT_W-1:0] out_pitch_ff, out_yaw_ff;

   always_comb begin
      pitch_rel = fold(f1_pitch_ff - ANG_W'(view_pitch_ff));
      yaw_rel   = fold(f1_yaw_ff - ANG_W'(view_yaw_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_pitch_ff <= pitch_rel[OUT_W-1:0];
         out_yaw_ff   <= yaw_rel[OUT_W-1:0];
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.pitch_offset = out_pitch_ff;
   assign rsp_chan.yaw_offset   = out_yaw_ff;

   // ---------------- assertions ----------------
   logic f1_in_range;
   assign f1_in_range = (f1_pitch_ff >= -HALF_TURN) && (f1_pitch_ff <= HALF_TURN) &&
                        (f1_yaw_ff >= -HALF_TURN) && (f1_yaw_ff <= HALF_TURN);

   // both CORDIC lanes must carry the same transaction
   `V2RA_CHECK(a_lanes_aligned, 1'b1, yaw_vld == pitch_vld)
   // first fold always lands within a half turn
   `V2RA_CHECK(a_fold_range, f1_vld_ff, f1_in_range)
   // reset empties the output register
   `V2RA_CHECK_NEXT(a_reset_clears, reset, !out_vld_ff)

endmodule
`default_nettype wire
